/* src/windowed_fft_spectrogram_db_assert.svh */
// Assertion macros used by the spectrogram checker file
`ifndef WINDOWED_FFT_SPECTROGRAM_DB_ASSERT_SVH
`define WINDOWED_FFT_SPECTROGRAM_DB_ASSERT_SVH

// Property checked outside reset
`define WFSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included
`define WFSD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* src/wfsd_pkg.sv */
// Shared constants, tables, types and states of the spectrogram block
package wfsd_pkg;

   localparam int FFT_SIZE  = 64;
   localparam int HOP       = 12;
   localparam int HALF      = FFT_SIZE / 2;
   localparam int AW        = $clog2(FFT_SIZE);
   localparam int KW        = AW + 1;
   localparam int CW        = $clog2(FFT_SIZE + 1);
   localparam int HW        = (HOP > 1) ? $clog2(HOP) : 1;
   localparam int LO_W      = 7;

   localparam int SAMPLE_W  = 16;
   localparam int TW_W      = 17;
   localparam int WIN_W     = 16;
   localparam int V_W       = 32;
   localparam int PROD_W    = V_W + TW_W;
   localparam int ACC_W     = PROD_W + 1 + AW;
   localparam int RND_SHIFT = 22;
   localparam int RW        = ACC_W - RND_SHIFT;
   localparam int PW        = 2 * RW;
   localparam int EW        = $clog2(PW);
   localparam int M_W       = 31;
   localparam int FRAC_W    = 12;
   localparam int IT_W      = $clog2(FRAC_W + 1);
   localparam int LG_W      = EW + FRAC_W + 1;
   localparam int DB_SHIFT  = 28;
   localparam int DBP_W     = LG_W + DB_SHIFT;
   localparam int DB_W      = 16;
   localparam int POS_W     = 6;
   localparam int CROP_W    = 5;

   localparam int DB_SCALE  = 25252226;
   localparam int DB_FLOOR  = -25600;
   localparam int DB_CEIL   = 25600;
   localparam int LG_OFFSET = 16 * 4096;
   localparam logic [WIN_W-1:0] RECT_WEIGHT = WIN_W'(32768);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP   = 2'd1;
   localparam int CSR_DATA_W = CROP_W;

   typedef logic signed [TW_W-1:0] tw_table_type [FFT_SIZE];
   typedef logic [WIN_W-1:0] win_table_type [FFT_SIZE];

   function automatic longint quarter_sine(input longint u);
      longint u2;
      longint acc;
      longint res;
      u2  = (u * u) >>> 14;
      acc = 172272;
      acc = -5026995 + ((acc * u2) >>> 14);
      acc = 85569306 + ((acc * u2) >>> 14);
      acc = -693598668 + ((acc * u2) >>> 14);
      acc = 1686629713 + ((acc * u2) >>> 14);
      res = (((acc * u) >>> 14) + 16384) >>> 15;
      if (res < 0) res = 0;
      if (res > 32767) res = 32767;
      return res;
   endfunction

   function automatic tw_table_type build_tw(input logic want_sin);
      tw_table_type t;
      longint a;
      longint q;
      longint r;
      longint s;
      longint c;
      longint v;
      for (int m = 0; m < FFT_SIZE; m++) begin
         a = ((longint'(m) * 65536 + HALF) / FFT_SIZE) & 65535;
         q = a >>> 14;
         r = a & 16383;
         s = quarter_sine(r);
         c = quarter_sine(16384 - r);
         case (q)
            0: v = want_sin ? s : c;
            1: v = want_sin ? c : -s;
            2: v = want_sin ? -s : -c;
            default: v = want_sin ? -c : s;
         endcase
         t[m] = TW_W'(v);
      end
      return t;
   endfunction

   localparam tw_table_type TW_COS = build_tw(1'b0);
   localparam tw_table_type TW_SIN = build_tw(1'b1);

   function automatic win_table_type build_win(input tw_table_type cosv);
      win_table_type t;
      longint v;
      for (int n = 0; n < FFT_SIZE; n++) begin
         v = (32768 - longint'(cosv[n])) >>> 1;
         t[n] = WIN_W'(v);
      end
      return t;
   endfunction

   localparam win_table_type HANN = build_win(TW_COS);

   typedef struct packed {
      logic              win_en;
      logic [CROP_W-1:0] crop;
   } cfg_type;

   typedef struct packed {
      logic                  en;
      logic [AW-1:0]         addr;
      logic [2*SAMPLE_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic          valid;
      logic [AW-1:0] start;
   } job_type;

   typedef struct packed {
      logic signed [DB_W-1:0] bin_db;
      logic [POS_W-1:0]       pos;
      logic                   last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_BIN,
      BK_MAC,
      BK_DRAIN,
      BK_ROUND,
      BK_POWER,
      BK_SUM,
      BK_NORM,
      BK_SQUARE,
      BK_SCALE,
      BK_PUSH
   } back_state_type;

endpackage

/* src/wfsd_ram.sv */
// Generic single-write, single-read RAM with registered read data
module wfsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/wfsd_front.sv */
// Front end: sample intake, store writes, capture and hop counting, frame jobs
module wfsd_front import wfsd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] sample_real,
   input  logic signed [SAMPLE_W-1:0] sample_imag,
   input  logic                       first_of_capture,
   input  logic                       back_busy,
   input  logic                       job_ready,
   output job_type                    job,
   output store_wr_type               store_wr
);

   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] seen_ff, seen_in, seen_base;
   logic [HW-1:0] hop_ff, hop_in, hop_base;
   logic [HW:0]   hop_next;
   job_type       job_ff, job_in;
   logic          accept;
   logic          frame;

   assign req_full = job_ff.valid | back_busy;
   assign accept   = req_push & ~req_full;

   always_comb begin
      seen_base = first_of_capture ? '0 : seen_ff;
      hop_base  = first_of_capture ? '0 : hop_ff;
      hop_next  = {1'b0, hop_base} + (HW+1)'(1);
      frame     = 1'b0;
      wp_in     = wp_ff;
      seen_in   = seen_ff;
      hop_in    = hop_ff;
      job_in    = job_ff;
      if (job_ff.valid && job_ready) begin
         job_in.valid = 1'b0;
      end
      if (accept) begin
         wp_in = (wp_ff == AW'(FFT_SIZE - 1)) ? '0 : wp_ff + AW'(1);
         if (seen_base < CW'(FFT_SIZE)) begin
            seen_in = seen_base + CW'(1);
            hop_in  = hop_base;
            if (seen_base == CW'(FFT_SIZE - 1)) begin
               frame  = 1'b1;
               hop_in = '0;
            end
         end else begin
            seen_in = seen_base;
            if (hop_next >= (HW+1)'(HOP)) begin
               frame  = 1'b1;
               hop_in = '0;
            end else begin
               hop_in = hop_next[HW-1:0];
            end
         end
         if (frame) begin
            job_in.valid = 1'b1;
            job_in.start = wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         seen_ff <= '0;
         hop_ff  <= '0;
         job_ff  <= '0;
      end else begin
         wp_ff   <= wp_in;
         seen_ff <= seen_in;
         hop_ff  <= hop_in;
         job_ff  <= job_in;
      end
   end

   assign job           = job_ff;
   assign store_wr.en   = accept;
   assign store_wr.addr = wp_ff;
   assign store_wr.data = {sample_real, sample_imag};

endmodule

/* src/wfsd_back.sv */
// Back end: per-bin DFT accumulation, power, log2 and dB scaling
module wfsd_back import wfsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  job_type               job,
   output logic                  job_ready,
   output logic                  busy,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [2*SAMPLE_W-1:0] rd_data,
   output logic                  push,
   output rsp_item_type          push_item,
   input  logic                  fifo_full
);

   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
   localparam logic signed [DBP_W-1:0] DB_HALF  = DBP_W'(1) << (DB_SHIFT - 1);
   localparam logic signed [DB_SHIFT-1:0] DB_SCALE_S = DB_SHIFT'(DB_SCALE);

   back_state_type state_ff, state_in;

   logic [AW-1:0]    start_ff, k_ff, n_ff, addr_ff, tw_ff;
   logic [POS_W-1:0] pos_ff;
   logic [KW-1:0]    total_ff;

   logic             v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]    n1_ff, t1_ff, t2_ff;
   logic signed [V_W-1:0]    vr2_ff, vi2_ff;
   logic signed [PROD_W-1:0] prc_ff, pis_ff, pic_ff, prs_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic signed [RW-1:0]     re_ff, im_ff;
   logic [PW-1:0]            sqr_ff, sqi_ff, p_ff;
   logic                     zero_ff;
   logic [EW-1:0]            e_ff;
   logic [M_W-1:0]           mant_ff;
   logic [FRAC_W-1:0]        frac_ff;
   logic [IT_W-1:0]          iter_ff;
   logic signed [DBP_W-1:0]  prod_ff;

   logic [LO_W-1:0] lo, cnt1, cnt2, total;
   logic [AW:0]     tw_sum;
   logic [AW-1:0]   tw_next;
   logic [WIN_W-1:0] weight;
   logic signed [SAMPLE_W+WIN_W:0] wr_prod, wi_prod;
   logic signed [PROD_W-1:0] mrc, mis, mic, mrs;
   logic signed [ACC_W-1:0]  rnd_re, rnd_im;
   logic signed [PW-1:0]     sq_re, sq_im;
   logic [2*M_W-1:0]         msq;
   logic [M_W:0]             mtop;
   logic signed [LG_W-1:0]   lgm;
   logic signed [DBP_W-1:0]  db_rnd;
   logic signed [LG_W-1:0]   db_full;
   logic signed [DB_W-1:0]   db_val;
   logic                     last;

   always_comb begin
      lo    = LO_W'(HALF) + LO_W'(cfg.crop);
      cnt1  = (lo < LO_W'(FFT_SIZE)) ? LO_W'(FFT_SIZE) - lo : '0;
      cnt2  = (LO_W'(cfg.crop) < LO_W'(HALF)) ? LO_W'(HALF) - LO_W'(cfg.crop) : '0;
      total = cnt1 + cnt2;
   end

   assign tw_sum  = {1'b0, tw_ff} + {1'b0, k_ff};
   assign tw_next = (tw_sum >= (AW+1)'(FFT_SIZE)) ? AW'(tw_sum - (AW+1)'(FFT_SIZE))
                                                  : tw_sum[AW-1:0];

   assign weight  = cfg.win_en ? HANN[n1_ff] : RECT_WEIGHT;
   assign wr_prod = $signed(rd_data[2*SAMPLE_W-1:SAMPLE_W]) * $signed({1'b0, weight});
   assign wi_prod = $signed(rd_data[SAMPLE_W-1:0]) * $signed({1'b0, weight});

   assign mrc = vr2_ff * TW_COS[t2_ff];
   assign mis = vi2_ff * TW_SIN[t2_ff];
   assign mic = vi2_ff * TW_COS[t2_ff];
   assign mrs = vr2_ff * TW_SIN[t2_ff];

   assign rnd_re = acc_re_ff + RND_HALF;
   assign rnd_im = acc_im_ff + RND_HALF;
   assign sq_re  = re_ff * re_ff;
   assign sq_im  = im_ff * im_ff;

   assign msq  = mant_ff * mant_ff;
   assign mtop = msq[2*M_W-1:M_W-1];

   assign lgm     = $signed({1'b0, e_ff, frac_ff}) - LG_W'(LG_OFFSET);
   assign db_rnd  = prod_ff + DB_HALF;
   assign db_full = db_rnd[DBP_W-1:DB_SHIFT];

   always_comb begin
      if (zero_ff || db_full < LG_W'(DB_FLOOR)) begin
         db_val = DB_W'(DB_FLOOR);
      end else if (db_full > LG_W'(DB_CEIL)) begin
         db_val = DB_W'(DB_CEIL);
      end else begin
         db_val = db_full[DB_W-1:0];
      end
   end

   assign last = ((KW'(pos_ff) + KW'(1)) == total_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job.valid && total != '0) state_in = BK_BIN;
         end
         BK_BIN: state_in = BK_MAC;
         BK_MAC: begin
            if (n_ff == AW'(FFT_SIZE - 1)) state_in = BK_DRAIN;
         end
         BK_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) state_in = BK_ROUND;
         end
         BK_ROUND: state_in = BK_POWER;
         BK_POWER: state_in = BK_SUM;
         BK_SUM:   state_in = BK_NORM;
         BK_NORM: begin
            if (p_ff == '0) state_in = BK_PUSH;
            else if (p_ff[PW-1]) state_in = BK_SQUARE;
         end
         BK_SQUARE: begin
            if (iter_ff == IT_W'(FRAC_W - 1)) state_in = BK_SCALE;
         end
         BK_SCALE: state_in = BK_PUSH;
         BK_PUSH: begin
            if (!fifo_full) state_in = last ? BK_IDLE : BK_BIN;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_ready = 1'b0;
      busy      = 1'b1;
      rd_en     = 1'b0;
      push      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            busy      = 1'b0;
         end
         BK_MAC:  rd_en = 1'b1;
         BK_PUSH: push  = ~fifo_full;
         default: ;
      endcase
   end

   assign rd_addr          = addr_ff;
   assign push_item.bin_db = db_val;
   assign push_item.pos    = pos_ff;
   assign push_item.last   = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == BK_MAC);
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff  <= n_ff;
      t1_ff  <= tw_ff;
      t2_ff  <= t1_ff;
      vr2_ff <= V_W'(wr_prod);
      vi2_ff <= V_W'(wi_prod);
      prc_ff <= mrc;
      pis_ff <= mis;
      pic_ff <= mic;
      prs_ff <= mrs;
      if (v3_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prc_ff) + ACC_W'(pis_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(pic_ff) - ACC_W'(prs_ff);
      end
      case (state_ff)
         BK_IDLE: begin
            start_ff <= job.start;
            total_ff <= KW'(total);
            k_ff     <= (cnt1 != '0) ? AW'(lo) : '0;
            pos_ff   <= '0;
         end
         BK_BIN: begin
            acc_re_ff <= '0;
            acc_im_ff <= '0;
            n_ff      <= '0;
            tw_ff     <= '0;
            addr_ff   <= start_ff;
         end
         BK_MAC: begin
            n_ff    <= n_ff + AW'(1);
            tw_ff   <= tw_next;
            addr_ff <= (addr_ff == AW'(FFT_SIZE - 1)) ? '0 : addr_ff + AW'(1);
         end
         BK_ROUND: begin
            re_ff <= rnd_re[ACC_W-1:RND_SHIFT];
            im_ff <= rnd_im[ACC_W-1:RND_SHIFT];
         end
         BK_POWER: begin
            sqr_ff <= sq_re;
            sqi_ff <= sq_im;
         end
         BK_SUM: begin
            p_ff    <= sqr_ff + sqi_ff;
            e_ff    <= EW'(PW - 1);
            zero_ff <= 1'b0;
         end
         BK_NORM: begin
            if (p_ff == '0) begin
               zero_ff <= 1'b1;
            end else if (p_ff[PW-1]) begin
               mant_ff <= p_ff[PW-1 -: M_W];
               frac_ff <= '0;
               iter_ff <= '0;
            end else if (p_ff[PW-1 -: 8] == '0) begin
               p_ff <= p_ff << 8;
               e_ff <= e_ff - EW'(8);
            end else begin
               p_ff <= p_ff << 1;
               e_ff <= e_ff - EW'(1);
            end
         end
         BK_SQUARE: begin
            iter_ff <= iter_ff + IT_W'(1);
            if (mtop[M_W]) begin
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b1};
               mant_ff <= mtop[M_W:1];
            end else begin
               frac_ff <= {frac_ff[FRAC_W-2:0], 1'b0};
               mant_ff <= mtop[M_W-1:0];
            end
         end
         BK_SCALE: prod_ff <= lgm * DB_SCALE_S;
         BK_PUSH: begin
            if (!fifo_full) begin
               pos_ff <= pos_ff + POS_W'(1);
               k_ff   <= (k_ff == AW'(FFT_SIZE - 1)) ? '0 : k_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

endmodule

/* src/wfsd_rsp_fifo.sv */
// Result queue between the back end and the result port
module wfsd_rsp_fifo import wfsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type pop_item
);

   rsp_item_type     mem_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ff, rd_ff;
   logic [RSP_AW:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (RSP_AW+1)'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (RSP_AW+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (RSP_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= wr_ff + RSP_AW'(1);
         if (do_pop)  rd_ff <= rd_ff + RSP_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* src/windowed_fft_spectrogram_db.sv */
// Top level of the windowed DFT spectrogram with dB output
// A sample that closes no frame does not raise req_full. The sample that
// completes a frame (the 64th of a capture, then every 12th) raises
// req_full until the last bin of the frame has entered the result queue.
// Each emitted bin takes a multiply-accumulate over the 64 stored samples
// (one stored sample read per cycle from the sample RAM), then rounding and
// power; a bin of nonzero power also goes through log2 normalization and 12
// squaring steps. A frame thus holds input until all of its bins are done
// (B = 50 bins at the reset crop of 7), longer while the result queue is
// full. Bins leave through a four-beat result queue, so the next samples are
// taken while results wait.
// The sample store is not cleared at reset; no frame reads an entry that the
// current capture has not written.
module windowed_fft_spectrogram_db import wfsd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_sample_real,
   input  logic signed [SAMPLE_W-1:0] req_sample_imag,
   input  logic                       req_first_of_capture,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [DB_W-1:0]     rsp_bin_db,
   output logic [POS_W-1:0]           rsp_bin_position,
   output logic                       rsp_last_bin,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cfg_type               cfg_ff;
   job_type               job;
   store_wr_type          store_wr;
   logic                  job_ready;
   logic                  back_busy;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [2*SAMPLE_W-1:0] rd_data;
   logic                  push;
   logic                  fifo_full;
   rsp_item_type          push_item;
   rsp_item_type          pop_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_en <= 1'b1;
         cfg_ff.crop   <= CROP_W'(7);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW: cfg_ff.win_en <= csr_data[0];
            CSR_CROP:   cfg_ff.crop   <= csr_data[CROP_W-1:0];
            default: ;
         endcase
      end
   end

   wfsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .sample_real      (req_sample_real),
      .sample_imag      (req_sample_imag),
      .first_of_capture (req_first_of_capture),
      .back_busy        (back_busy),
      .job_ready        (job_ready),
      .job              (job),
      .store_wr         (store_wr)
   );

   wfsd_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (FFT_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wfsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (job),
      .job_ready (job_ready),
      .busy      (back_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .push      (push),
      .push_item (push_item),
      .fifo_full (fifo_full)
   );

   wfsd_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_item  (pop_item)
   );

   assign rsp_bin_db       = pop_item.bin_db;
   assign rsp_bin_position = pop_item.pos;
   assign rsp_last_bin     = pop_item.last;

endmodule

/* src/wfsd_checker.sv */
// Port-level assertions for the spectrogram block and their bind
`include "windowed_fft_spectrogram_db_assert.svh"

module wfsd_checker import wfsd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic signed [DB_W-1:0] rsp_bin_db,
   input logic [POS_W-1:0]       rsp_bin_position,
   input logic                   rsp_last_bin
);

   `WFSD_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result queue not empty after reset")
   `WFSD_ASSERT_ALWAYS(a_reset_ready, reset |=> !req_full, "input not open after reset")
   `WFSD_ASSERT(a_rsp_hold, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_bin_db) && $stable(rsp_bin_position) && $stable(rsp_last_bin), "stalled result beat changed")

endmodule

bind windowed_fft_spectrogram_db wfsd_checker u_wfsd_checker (.*);
